// File: rtl/wpne_pkg.sv
package wpne_pkg;

	localparam int unsigned NOW_W    = 63;
	localparam int unsigned PERIOD_W = 50;
	localparam int unsigned OFFS_W   = 47;
	localparam int unsigned OUT_W    = 34;
	localparam int unsigned SUM_W    = 64;
	localparam int unsigned SEC_W    = 30;

	localparam logic [SUM_W-1:0]    DAYS    = 64'd86400000000000;
	localparam logic [SEC_W-1:0]    SECONDS = 30'd1000000000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 50'd3600000000000;

	// one second is 2^9 times 5^9; the odd part is divided by reciprocal steps
	localparam int unsigned SEC_SHIFT   = 9;
	localparam int unsigned ODD_W       = 21;
	localparam int unsigned CHUNK_W     = 11;
	localparam int unsigned DIV_W       = ODD_W + CHUNK_W;
	localparam int unsigned RECIP_W     = 33;
	localparam int unsigned RECIP_SHIFT = 53;

	localparam logic [ODD_W-1:0]   SEC_ODD   = ODD_W'(SECONDS >> SEC_SHIFT);
	localparam logic [RECIP_W-1:0] SEC_RECIP = 33'd4611686019;

	typedef enum logic [1:0] {
		REG_PERIOD = 2'd0,
		REG_START  = 2'd1,
		REG_END    = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

endpackage

// File: rtl/windowed_periodic_next_event_top.sv
// throughput: one query per cycle; a 64-step bit-serial remainder pipeline, then a
// divide by one second as a 9-bit shift and four reciprocal steps of two stages each
// the whole pipeline advances together and holds while a result waits untaken
// reset clears all valid bits and loads the register defaults
module windowed_periodic_next_event_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [wpne_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wpne_pkg::NOW_W-1:0]    now_ns,
	input  logic [wpne_pkg::NOW_W-1:0]    day_start_ns,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wpne_pkg::OUT_W-1:0]    next_time_s
);

	localparam int unsigned MSTEPS  = wpne_pkg::SUM_W;
	localparam int unsigned DSTEPS  = 4;
	localparam int unsigned X_W     = wpne_pkg::SUM_W - wpne_pkg::SEC_SHIFT;
	localparam int unsigned FIRST_W = X_W - (DSTEPS - 1) * wpne_pkg::CHUNK_W;

	logic [wpne_pkg::PERIOD_W-1:0] period_q;
	logic [wpne_pkg::OFFS_W-1:0]   start_q;
	logic [wpne_pkg::OFFS_W-1:0]   end_q;
	logic                          en;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= wpne_pkg::PERIOD_RESET;
			start_q  <= '0;
			end_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wpne_pkg::cfg_reg_t'(cfg_index))
				wpne_pkg::REG_PERIOD: period_q <= cfg_data;
				wpne_pkg::REG_START:  start_q  <= cfg_data[wpne_pkg::OFFS_W-1:0];
				wpne_pkg::REG_END:    end_q    <= cfg_data[wpne_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: window edges
	logic                          v_s1;
	logic [63:0]                   now_s1, s_s1, e_s1, y_s1;
	logic [wpne_pkg::PERIOD_W-1:0] p_s1;
	logic                          wrap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			now_s1  <= {1'b0, now_ns};
			s_s1    <= {1'b0, day_start_ns} + {17'b0, start_q};
			e_s1    <= {1'b0, day_start_ns} + {17'b0, end_q};
			y_s1    <= {1'b0, day_start_ns} + {17'b0, start_q} - wpne_pkg::DAYS;
			p_s1    <= (period_q == '0) ? wpne_pkg::PERIOD_W'(1) : period_q;
			wrap_s1 <= end_q < start_q;
		end
	end

	// remainder pipeline, index 0 is stage 2
	logic                          mv_s   [0:MSTEPS];
	logic [63:0]                   mx_s   [0:MSTEPS];
	logic [63:0]                   mb_s   [0:MSTEPS];
	logic [wpne_pkg::PERIOD_W-1:0] mp_s   [0:MSTEPS];
	logic [wpne_pkg::PERIOD_W-1:0] mr_s   [0:MSTEPS];
	logic                          mdir_s [0:MSTEPS];
	logic                          mneg_s [0:MSTEPS];

	logic [63:0] x_c, b_c;
	logic        dir_c, neg_c;

	always_comb begin
		x_c   = '0;
		b_c   = now_s1 + {14'b0, p_s1};
		dir_c = 1'b0;
		neg_c = 1'b0;
		if (wrap_s1) begin
			priority if (now_s1 > e_s1 && now_s1 < s_s1) begin
				dir_c = 1'b1;
				b_c   = s_s1;
			end else if (now_s1 > s_s1) begin
				x_c = now_s1 - s_s1;
			end else if (s_s1 >= wpne_pkg::DAYS) begin
				if (now_s1 >= y_s1) x_c = now_s1 - y_s1;
				else begin
					x_c   = y_s1 - now_s1;
					neg_c = 1'b1;
				end
			end else begin
				x_c = now_s1 - y_s1;
			end
		end else begin
			priority if (now_s1 < e_s1 && now_s1 > s_s1) begin
				x_c = now_s1 - s_s1;
			end else if (now_s1 < s_s1) begin
				dir_c = 1'b1;
				b_c   = s_s1;
			end else begin
				dir_c = 1'b1;
				b_c   = s_s1 + wpne_pkg::DAYS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mv_s[0] <= 1'b0;
		else if (en) mv_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s[0]   <= x_c;
			mb_s[0]   <= b_c;
			mp_s[0]   <= p_s1;
			mr_s[0]   <= '0;
			mdir_s[0] <= dir_c;
			mneg_s[0] <= neg_c;
		end
	end

	for (genvar k = 1; k <= MSTEPS; k++) begin : g_mod
		logic [wpne_pkg::PERIOD_W:0] t;
		logic [wpne_pkg::PERIOD_W:0] d;
		assign t = {mr_s[k-1], mx_s[k-1][MSTEPS-k]};
		assign d = t - {1'b0, mp_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) mv_s[k] <= 1'b0;
			else if (en) mv_s[k] <= mv_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mx_s[k]   <= mx_s[k-1];
				mb_s[k]   <= mb_s[k-1];
				mp_s[k]   <= mp_s[k-1];
				mdir_s[k] <= mdir_s[k-1];
				mneg_s[k] <= mneg_s[k-1];
				mr_s[k]   <= (t >= {1'b0, mp_s[k-1]}) ?
					d[wpne_pkg::PERIOD_W-1:0] : t[wpne_pkg::PERIOD_W-1:0];
			end
		end
	end

	// divide by one second: drop 2^9, then divide by 5^9 a chunk at a time
	logic                          dva_s [1:DSTEPS];
	logic                          dvb_s [0:DSTEPS];
	logic [X_W-1:0]                dxa_s [1:DSTEPS];
	logic [X_W-1:0]                dxb_s [0:DSTEPS];
	logic [wpne_pkg::DIV_W-1:0]    dya_s [1:DSTEPS];
	logic [wpne_pkg::CHUNK_W-1:0]  dqv_s [1:DSTEPS];
	logic [wpne_pkg::OUT_W-1:0]    dqa_s [1:DSTEPS];
	logic [wpne_pkg::OUT_W-1:0]    dqb_s [1:DSTEPS];
	logic [wpne_pkg::ODD_W-1:0]    drb_s [1:DSTEPS];
	logic [63:0]                   next_c;

	always_comb begin
		if (mdir_s[MSTEPS])      next_c = mb_s[MSTEPS];
		else if (mneg_s[MSTEPS]) next_c = mb_s[MSTEPS] + {14'b0, mr_s[MSTEPS]};
		else                     next_c = mb_s[MSTEPS] - {14'b0, mr_s[MSTEPS]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvb_s[0] <= 1'b0;
		else if (en) dvb_s[0] <= mv_s[MSTEPS];
	end

	always_ff @(posedge clk) begin
		if (en) dxb_s[0] <= next_c[wpne_pkg::SUM_W-1:wpne_pkg::SEC_SHIFT];
	end

	for (genvar j = 1; j <= DSTEPS; j++) begin : g_div
		logic [wpne_pkg::DIV_W-1:0] y;
		logic [wpne_pkg::OUT_W-1:0] qin;
		logic [wpne_pkg::SUM_W-1:0] prod;
		logic [wpne_pkg::DIV_W-1:0] qd;
		logic [wpne_pkg::DIV_W-1:0] rem;

		if (j == 1) begin : g_first
			assign y   = wpne_pkg::DIV_W'(dxb_s[j-1][X_W-1:X_W-FIRST_W]);
			assign qin = '0;
		end else begin : g_rest
			assign y   = {drb_s[j-1],
				dxb_s[j-1][X_W-1-FIRST_W-(j-2)*wpne_pkg::CHUNK_W -: wpne_pkg::CHUNK_W]};
			assign qin = dqb_s[j-1];
		end

		// exact for any 32-bit numerator; numerators here stay below 5^9 * 2^11, so the product stays below 2^64
		assign prod = wpne_pkg::SUM_W'(y) * wpne_pkg::SUM_W'(wpne_pkg::SEC_RECIP);
		assign qd   = wpne_pkg::DIV_W'(dqv_s[j]) * wpne_pkg::DIV_W'(wpne_pkg::SEC_ODD);
		assign rem  = dya_s[j] - qd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dva_s[j] <= 1'b0;
			else if (en) dva_s[j] <= dvb_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dxa_s[j] <= dxb_s[j-1];
				dya_s[j] <= y;
				dqv_s[j] <= prod[wpne_pkg::RECIP_SHIFT+wpne_pkg::CHUNK_W-1:
					wpne_pkg::RECIP_SHIFT];
				dqa_s[j] <= qin;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvb_s[j] <= 1'b0;
			else if (en) dvb_s[j] <= dva_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dxb_s[j] <= dxa_s[j];
				drb_s[j] <= rem[wpne_pkg::ODD_W-1:0];
				dqb_s[j] <= {dqa_s[j][wpne_pkg::OUT_W-wpne_pkg::CHUNK_W-1:0], dqv_s[j]};
			end
		end
	end

	logic                       out_valid_q;
	logic [wpne_pkg::OUT_W-1:0] next_time_s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dvb_s[DSTEPS];
	end

	always_ff @(posedge clk) begin
		if (en) next_time_s_q <= dqb_s[DSTEPS];
	end

	assign out_valid   = out_valid_q;
	assign next_time_s = next_time_s_q;

	a_mod_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s[MSTEPS] |-> (mr_s[MSTEPS] < mp_s[MSTEPS]))
		else $error("remainder not below period");

	a_div_rem_below_odd: assert property (@(posedge clk) disable iff (!arst_n)
		dvb_s[DSTEPS] |-> (drb_s[DSTEPS] < wpne_pkg::SEC_ODD))
		else $error("seconds remainder out of range");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(dvb_s[DSTEPS]) && $stable(mv_s[MSTEPS])))
		else $error("pipeline moved during stall");

endmodule

// File: tb/tb_windowed_periodic_next_event_top.sv
`timescale 1ns / 100ps

module tb_windowed_periodic_next_event_top;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam logic [63:0] ONE_DAY = 64'd86400000000000;
	localparam logic [63:0] ONE_SEC = 64'd1000000000;
	localparam logic [63:0] MAX63 = (64'd1 << 63) - 64'd1;
	localparam logic [63:0] MAX50 = (64'd1 << 50) - 64'd1;
	localparam logic [63:0] MAX47 = (64'd1 << 47) - 64'd1;

	typedef struct packed {
		logic [wpne_pkg::NOW_W-1:0] now;
		logic [wpne_pkg::NOW_W-1:0] day;
	} query_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = wpne_pkg::REG_PERIOD;
	logic [wpne_pkg::PERIOD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [wpne_pkg::NOW_W-1:0] now_ns = '0;
	logic [wpne_pkg::NOW_W-1:0] day_start_ns = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [wpne_pkg::OUT_W-1:0] next_time_s;

	query_t pending_queries[$];
	logic [wpne_pkg::OUT_W-1:0] expected_times[$];
	logic [63:0] m_period = 64'd3600000000000;
	logic [63:0] m_start = 64'd0;
	logic [63:0] m_end = 64'd0;
	bit quiet = 1'b0;
	int unsigned errors = 0;
	int unsigned stall_cycles = 0;

	windowed_periodic_next_event_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .now_ns(now_ns),
		.day_start_ns(day_start_ns),
		.out_valid(out_valid), .out_ready(out_ready), .next_time_s(next_time_s)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] boundary_after(logic [63:0] t, logic [63:0] origin,
			logic [63:0] p);
		if (t >= origin)
			return t + (p - ((t - origin) % p));
		return t + p + ((origin - t) % p);
	endfunction

	function automatic logic [wpne_pkg::OUT_W-1:0] next_event_s(query_t q);
		logic [63:0] t, p, s, e, nxt;
		t = {1'b0, q.now};
		p = (m_period == 0) ? 64'd1 : m_period;
		s = {1'b0, q.day} + m_start;
		e = {1'b0, q.day} + m_end;
		if (m_end < m_start) begin
			if (t > e && t < s)
				nxt = s;
			else if (t > s)
				nxt = boundary_after(t, s, p);
			else if (s >= ONE_DAY)
				nxt = boundary_after(t, s - ONE_DAY, p);
			else
				nxt = t + (p - ((t + (ONE_DAY - s)) % p));
		end else begin
			if (t < e && t > s)
				nxt = boundary_after(t, s, p);
			else if (t < s)
				nxt = s;
			else
				nxt = s + ONE_DAY;
		end
		return wpne_pkg::OUT_W'(nxt / ONE_SEC);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic report(string what, logic [wpne_pkg::OUT_W-1:0] got,
			logic [wpne_pkg::OUT_W-1:0] want);
		$display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_times.push_back(next_event_s('{now_ns, day_start_ns}));
			if (in_valid && !in_ready) begin
			end else if (pending_queries.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
				query_t q;
				q = pending_queries.pop_front();
				now_ns <= q.now;
				day_start_ns <= q.day;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_times.size() == 0)
					report("unexpected result", next_time_s, '0);
				else begin
					logic [wpne_pkg::OUT_W-1:0] want;
					want = expected_times.pop_front();
					if (next_time_s !== want)
						report("next_time_s", next_time_s, want);
				end
			end
			out_ready <= quiet || $urandom_range(99) >= 23;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(wpne_pkg::cfg_reg_t idx, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= wpne_pkg::PERIOD_W'(value);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wpne_pkg::REG_PERIOD: m_period = value & MAX50;
			wpne_pkg::REG_START:  m_start = value & MAX47;
			wpne_pkg::REG_END:    m_end = value & MAX47;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic add_query(logic [63:0] t, logic [63:0] d);
		pending_queries.push_back('{wpne_pkg::NOW_W'(t & MAX63), wpne_pkg::NOW_W'(d & MAX63)});
	endtask

	task automatic run_phase(int unsigned n);
		logic [63:0] d, s, e;
		d = rand64() & MAX63;
		if (d > MAX63 - 4 * ONE_DAY)
			d = d - 4 * ONE_DAY;
		s = d + m_start;
		e = d + m_end;
		add_query(0, 0);
		add_query(MAX63, MAX63);
		add_query(MAX63, 0);
		add_query(0, MAX63);
		add_query(s, d);
		add_query(s - 1, d);
		add_query(s + 1, d);
		add_query(e, d);
		add_query(e - 1, d);
		add_query(e + 1, d);
		add_query(d + ONE_DAY - 1, d);
		add_query(d > 3 * ONE_DAY ? d - 3 * ONE_DAY : 0, d);
		add_query(m_start, 0);
		for (int i = 0; i < n; i++) begin
			int unsigned kind;
			logic [63:0] t;
			kind = $urandom_range(9);
			if (kind == 0) begin
				add_query(rand64(), rand64());
			end else begin
				d = (kind == 1) ? 64'($urandom_range(3)) * ONE_DAY : rand64() & MAX63;
				if (d > MAX63 - 4 * ONE_DAY)
					d = d - 4 * ONE_DAY;
				t = d + (rand64() % (3 * ONE_DAY));
				if (d >= ONE_DAY)
					t = t - ONE_DAY;
				if (kind == 2)
					t = d + m_start + 64'($urandom_range(4)) - 2;
				else if (kind == 3)
					t = d + m_end + 64'($urandom_range(4)) - 2;
				add_query(t, d);
			end
		end
		while (pending_queries.size() != 0 || in_valid || expected_times.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(87);
		quiet = 1'b1;
		run_phase(87);
		quiet = 1'b0;
		write_reg(wpne_pkg::REG_PERIOD, 1);
		write_reg(wpne_pkg::REG_START, 0);
		write_reg(wpne_pkg::REG_END, ONE_DAY - 1);
		run_phase(87);
		write_reg(wpne_pkg::REG_PERIOD, MAX50);
		write_reg(wpne_pkg::REG_START, MAX47);
		write_reg(wpne_pkg::REG_END, 0);
		run_phase(87);
		write_reg(wpne_pkg::REG_PERIOD, 0);
		write_reg(wpne_pkg::REG_START, ONE_DAY - 1);
		write_reg(wpne_pkg::REG_END, ONE_DAY - 1);
		run_phase(87);
		write_reg(wpne_pkg::REG_NONE, MAX50);
		write_reg(wpne_pkg::REG_PERIOD, 64'd604800000000000);
		write_reg(wpne_pkg::REG_START, 64'd3600000000000);
		write_reg(wpne_pkg::REG_END, 64'd1800000000000);
		run_phase(87);
		write_reg(wpne_pkg::REG_PERIOD, 64'd7);
		write_reg(wpne_pkg::REG_START, 64'd79200000000000);
		write_reg(wpne_pkg::REG_END, 64'd21600000000000);
		run_phase(87);
		write_reg(wpne_pkg::REG_PERIOD, 64'd900000000000);
		write_reg(wpne_pkg::REG_START, 64'd28800000000000);
		write_reg(wpne_pkg::REG_END, 64'd64800000000000);
		run_phase(87);
		for (int k = 0; k < 3; k++) begin
			write_reg(wpne_pkg::REG_PERIOD, 64'($urandom_range(1, 1000)) * 64'($urandom));
			write_reg(wpne_pkg::REG_START, rand64() % ONE_DAY);
			write_reg(wpne_pkg::REG_END, rand64() % ONE_DAY);
			run_phase(87);
		end
		repeat (150) @(posedge clk);
		if (errors == 0 && expected_times.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/wpne_pkg.sv
rtl/windowed_periodic_next_event_top.sv
tb/tb_windowed_periodic_next_event_top.sv
